// File: src/vtpd_pkg.sv
package vtpd_pkg;

   localparam int COORD_W   = 32;
   localparam int COEF_W    = 16;
   localparam int MAT_W     = 64;
   localparam int ROWS      = 4;
   localparam int COLS      = 4;
   localparam int PROD_W    = COORD_W + COEF_W;
   localparam int SUM_W     = 50;
   localparam int MAG_W     = 49;
   localparam int FRAC_SH   = 16;
   localparam int QUOT_W    = 33;
   localparam int CSR_IDX_W = 8;
   localparam int MAC_LAT   = 2;
   localparam int PREP_LAT  = 1;
   localparam int DIV_LAT   = QUOT_W + 2;
   localparam int TOTAL_LAT = MAC_LAT + PREP_LAT + DIV_LAT;

   localparam logic [MAG_W-1:0] ONE_Q28 = MAG_W'(1) << 28;

   localparam logic [MAT_W-1:0] MAT_COL0_RST = MAT_W'(64'h0000_0000_0000_1000);
   localparam logic [MAT_W-1:0] MAT_COL1_RST = MAT_W'(64'h0000_0000_1000_0000);
   localparam logic [MAT_W-1:0] MAT_COL2_RST = MAT_W'(64'h0000_1000_0000_0000);
   localparam logic [MAT_W-1:0] MAT_COL3_RST = MAT_W'(64'h1000_0000_0000_0000);

   localparam logic [CSR_IDX_W-1:0] CSR_MAT_COL0 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAT_COL1 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MAT_COL2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_MAT_COL3 = CSR_IDX_W'(3);

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [MAT_W-1:0]        col_type;

endpackage

// File: src/vtpd_if.sv
interface vtpd_req_if import vtpd_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [COORD_W-1:0] src_y;
   logic signed [COORD_W-1:0] src_z;
   logic signed [COORD_W-1:0] src_x;
   modport source (output valid, src_y, src_z, src_x, input ready);
   modport sink (input valid, src_y, src_z, src_x, output ready);
endinterface

interface vtpd_rsp_if import vtpd_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [COORD_W-1:0] dst_y;
   logic signed [COORD_W-1:0] dst_z;
   logic signed [COORD_W-1:0] dst_x;
   logic divided;
   logic saturated;
   modport source (output valid, dst_y, dst_z, dst_x, divided, saturated, input ready);
   modport sink (input valid, dst_y, dst_z, dst_x, divided, saturated, output ready);
endinterface

interface vtpd_csr_if import vtpd_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0] index;
   logic [MAT_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: src/vtpd_mac.sv
module vtpd_mac import vtpd_pkg::*; (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [COORD_W-1:0] src_y,
   input  logic signed [COORD_W-1:0] src_z,
   input  logic signed [COORD_W-1:0] src_x,
   input  col_type                   cols [COLS],
   output sum_type                   sums [COLS]
);

   logic signed [PROD_W-1:0] prod_ff [COLS][ROWS-1];
   logic signed [PROD_W-1:0] prod_in [COLS][ROWS-1];
   logic signed [COEF_W-1:0] kterm_ff [COLS];
   sum_type                  sum_ff [COLS];
   sum_type                  sum_in [COLS];
   logic signed [COORD_W-1:0] vec [ROWS-1];

   assign vec[0] = src_y;
   assign vec[1] = src_z;
   assign vec[2] = src_x;

   always_comb begin
      for (int c = 0; c < COLS; c++) begin
         for (int r = 0; r < ROWS - 1; r++) begin
            prod_in[c][r] = PROD_W'(vec[r]) *
                            PROD_W'($signed(cols[c][r*COEF_W +: COEF_W]));
         end
         // constant row aligned to q.28
         sum_in[c] = SUM_W'(prod_ff[c][0]) + SUM_W'(prod_ff[c][1]) + SUM_W'(prod_ff[c][2])
                   + (SUM_W'(kterm_ff[c]) <<< FRAC_SH);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < COLS; c++) begin
            prod_ff[c]  <= prod_in[c];
            kterm_ff[c] <= $signed(cols[c][(ROWS-1)*COEF_W +: COEF_W]);
            sum_ff[c]   <= sum_in[c];
         end
      end
   end

   assign sums = sum_ff;

endmodule

// File: src/vtpd_div_lane.sv
module vtpd_div_lane import vtpd_pkg::*; (
   input  logic                      clock,
   input  logic                      en,
   input  logic [MAG_W-1:0]          num,
   input  logic [MAG_W-1:0]          den,
   input  logic                      neg,
   output logic signed [COORD_W-1:0] quot,
   output logic                      sat
);

   logic [MAG_W-1:0]  rem_ff [QUOT_W+1];
   logic [QUOT_W-1:0] low_ff [QUOT_W+1];
   logic [QUOT_W-1:0] q_ff   [QUOT_W+1];
   logic [MAG_W-1:0]  den_ff [QUOT_W+1];
   logic              neg_ff [QUOT_W+1];
   logic              ovf_ff [QUOT_W+1];
   logic [MAG_W:0]    trial  [QUOT_W];
   logic              take   [QUOT_W];
   logic signed [COORD_W-1:0] quot_ff, quot_in;
   logic              sat_ff, sat_in;
   logic [QUOT_W-1:0] qf;

   always_comb begin
      for (int k = 0; k < QUOT_W; k++) begin
         trial[k] = {rem_ff[k], low_ff[k][QUOT_W-1]};
         take[k]  = trial[k] >= {1'b0, den_ff[k]};
      end
   end

   // final quotient bounds: positive up to 0x7fffffff, negative down to -0x80000000
   always_comb begin
      qf = q_ff[QUOT_W];
      if (!neg_ff[QUOT_W]) begin
         sat_in  = ovf_ff[QUOT_W] || (qf > QUOT_W'(32'h7FFF_FFFF));
         quot_in = sat_in ? COORD_W'(32'h7FFF_FFFF) : $signed(qf[COORD_W-1:0]);
      end else begin
         sat_in  = ovf_ff[QUOT_W] || (qf > QUOT_W'(32'h8000_0000));
         quot_in = sat_in ? COORD_W'(32'h8000_0000) : -$signed(qf[COORD_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // high part must be below the divisor or the quotient overflows
         rem_ff[0] <= MAG_W'(num[MAG_W-1:QUOT_W-FRAC_SH]);
         low_ff[0] <= {num[QUOT_W-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= neg;
         ovf_ff[0] <= MAG_W'(num[MAG_W-1:QUOT_W-FRAC_SH]) >= den;
         for (int k = 0; k < QUOT_W; k++) begin
            rem_ff[k+1] <= take[k] ? MAG_W'(trial[k] - {1'b0, den_ff[k]})
                                   : MAG_W'(trial[k]);
            low_ff[k+1] <= low_ff[k] << 1;
            q_ff[k+1]   <= {q_ff[k][QUOT_W-2:0], take[k]};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
         quot_ff <= quot_in;
         sat_ff  <= sat_in;
      end
   end

   assign quot = quot_ff;
   assign sat  = sat_ff;

endmodule

// File: src/vertex_transform_perspective_divide.sv
// throughput: one vertex per cycle, limited by nothing but the output handshake
// the whole pipeline holds while a finished result waits on rsp
// reset clears all valid bits and loads the identity matrix
module vertex_transform_perspective_divide import vtpd_pkg::*; (
   input logic        clock,
   input logic        reset,
   vtpd_req_if.sink   req_ch,
   vtpd_rsp_if.source rsp_ch,
   vtpd_csr_if.sink   csr_ch
);

   col_type mat_ff [COLS];
   sum_type sums [COLS];
   logic    en;
   logic [TOTAL_LAT-1:0] vld_ff;
   logic [DIV_LAT:0]     div_ff;
   logic [MAG_W-1:0] mag_ff [COLS-1];
   logic             neg_ff [COLS-1];
   logic [MAG_W-1:0] wmag_ff;
   logic             wneg;
   logic signed [COORD_W-1:0] quot [COLS-1];
   logic             sat [COLS-1];

   assign en            = !vld_ff[TOTAL_LAT-1] || rsp_ch.ready;
   assign req_ch.ready  = en;
   assign csr_ch.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[0] <= MAT_COL0_RST;
         mat_ff[1] <= MAT_COL1_RST;
         mat_ff[2] <= MAT_COL2_RST;
         mat_ff[3] <= MAT_COL3_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_MAT_COL0: mat_ff[0] <= csr_ch.data;
            CSR_MAT_COL1: mat_ff[1] <= csr_ch.data;
            CSR_MAT_COL2: mat_ff[2] <= csr_ch.data;
            CSR_MAT_COL3: mat_ff[3] <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_ch.valid};
      end
   end

   vtpd_mac u_mac (
      .clock (clock),
      .en    (en),
      .src_y (req_ch.src_y),
      .src_z (req_ch.src_z),
      .src_x (req_ch.src_x),
      .cols  (mat_ff),
      .sums  (sums)
   );

   assign wneg = sums[COLS-1][SUM_W-1];

   // magnitudes and signs; zero w divides by 1.0
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < COLS - 1; c++) begin
            mag_ff[c] <= sums[c][SUM_W-1] ? MAG_W'(-sums[c]) : MAG_W'(sums[c]);
            neg_ff[c] <= sums[c][SUM_W-1] ^ wneg;
         end
         if (sums[COLS-1] == '0) begin
            wmag_ff <= ONE_Q28;
         end else begin
            wmag_ff <= wneg ? MAG_W'(-sums[COLS-1]) : MAG_W'(sums[COLS-1]);
         end
         div_ff <= {div_ff[DIV_LAT-1:0], sums[COLS-1] != '0};
      end
   end

   for (genvar c = 0; c < COLS - 1; c++) begin : g_lane
      vtpd_div_lane u_lane (
         .clock (clock),
         .en    (en),
         .num   (mag_ff[c]),
         .den   (wmag_ff),
         .neg   (neg_ff[c]),
         .quot  (quot[c]),
         .sat   (sat[c])
      );
   end

   assign rsp_ch.valid     = vld_ff[TOTAL_LAT-1];
   assign rsp_ch.dst_y     = quot[0];
   assign rsp_ch.dst_z     = quot[1];
   assign rsp_ch.dst_x     = quot[2];
   assign rsp_ch.divided   = div_ff[DIV_LAT];
   assign rsp_ch.saturated = sat[0] | sat[1] | sat[2];

endmodule

// File: bench/vtpd_checker.sv
`timescale 1ns / 1ps
module vtpd_checker import vtpd_pkg::*; (
   input logic clock,
   input logic reset,
   vtpd_req_if.sink req_mon,
   vtpd_rsp_if.sink rsp_mon,
   vtpd_csr_if.sink csr_mon,
   output int fail_count,
   output int pending,
   output int vertex_count,
   output int div_count,
   output int sat_count
);

   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] x;
      logic divided;
      logic saturated;
   } vertex_out_type;

   col_type mat [COLS];
   vertex_out_type vertex_q [$];

   function automatic logic signed [63:0] coef(col_type col, int row);
      logic signed [COEF_W-1:0] s;
      s = col[row*COEF_W +: COEF_W];
      return 64'(s);
   endfunction

   function automatic logic signed [63:0] col_sum(col_type col, logic signed [63:0] y,
                                                  logic signed [63:0] z,
                                                  logic signed [63:0] x);
      return y * coef(col, 0) + z * coef(col, 1) + x * coef(col, 2)
             + coef(col, 3) * 64'sd65536;
   endfunction

   // quotient in Q16.16 with truncation toward zero, clamped to 32 bits
   function automatic logic [31:0] div_clamp(logic signed [63:0] c, logic [63:0] wmag,
                                             logic wneg, inout logic sat);
      logic neg;
      logic [127:0] num, q;
      logic [63:0] cmag;
      neg = (c < 0) != wneg;
      cmag = c < 0 ? -c : c;
      num = {64'd0, cmag} << 16;
      q = num / {64'd0, wmag};
      if (!neg) begin
         if (q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
         end
         return q[31:0];
      end
      if (q > 128'h8000_0000) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return 32'(-q[31:0]);
   endfunction

   function automatic vertex_out_type transform(logic signed [31:0] sy,
                                                logic signed [31:0] sz,
                                                logic signed [31:0] sx);
      logic signed [63:0] cy, cz, cx, w;
      logic [63:0] wmag;
      logic wneg, sat;
      vertex_out_type r;
      cy = col_sum(mat[0], sy, sz, sx);
      cz = col_sum(mat[1], sy, sz, sx);
      cx = col_sum(mat[2], sy, sz, sx);
      w = col_sum(mat[3], sy, sz, sx);
      sat = 1'b0;
      wneg = w < 0;
      wmag = (w == 0) ? 64'(ONE_Q28) : (wneg ? -w : w);
      r.y = div_clamp(cy, wmag, wneg, sat);
      r.z = div_clamp(cz, wmag, wneg, sat);
      r.x = div_clamp(cx, wmag, wneg, sat);
      r.divided = (w != 0);
      r.saturated = sat;
      return r;
   endfunction

   always @(posedge clock) begin
      vertex_out_type e, a;
      if (reset) begin
         mat[0] <= MAT_COL0_RST;
         mat[1] <= MAT_COL1_RST;
         mat[2] <= MAT_COL2_RST;
         mat[3] <= MAT_COL3_RST;
         vertex_q.delete();
         pending <= 0;
         fail_count <= 0;
         vertex_count <= 0;
         div_count <= 0;
         sat_count <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_MAT_COL0: mat[0] <= csr_mon.data;
               CSR_MAT_COL1: mat[1] <= csr_mon.data;
               CSR_MAT_COL2: mat[2] <= csr_mon.data;
               CSR_MAT_COL3: mat[3] <= csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            vertex_q.insert(vertex_q.size(),
                            transform(req_mon.src_y, req_mon.src_z, req_mon.src_x));
         if (rsp_mon.valid && rsp_mon.ready) begin
            a = '{rsp_mon.dst_y, rsp_mon.dst_z, rsp_mon.dst_x,
                  rsp_mon.divided, rsp_mon.saturated};
            vertex_count <= vertex_count + 1;
            if (vertex_q.size() == 0) begin
               $display("%0t: unexpected rsp transfer, actual %h", $time, a);
               fail_count <= fail_count + 1;
            end else begin
               e = vertex_q.pop_front();
               div_count <= div_count + e.divided;
               sat_count <= sat_count + e.saturated;
               if (e !== a) begin
                  $display("%0t: mismatch expected y=%h z=%h x=%h div=%b sat=%b",
                           $time, e.y, e.z, e.x, e.divided, e.saturated);
                  $display("%0t:          actual   y=%h z=%h x=%h div=%b sat=%b",
                           $time, a.y, a.z, a.x, a.divided, a.saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= vertex_q.size();
      end
   end

endmodule

// File: bench/tb_vertex_transform_perspective_divide.sv
`timescale 1ns / 1ps
module tb_vertex_transform_perspective_divide;
   import vtpd_pkg::*;

   localparam int LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int cycle = 0;
   int req_idle = 0;
   int rsp_idle = 0;
   int fail_count, pending, vertex_count, div_count, sat_count;

   vtpd_req_if req_ch ();
   vtpd_rsp_if rsp_ch ();
   vtpd_csr_if csr_ch ();

   vertex_transform_perspective_divide u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   vtpd_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch), .csr_mon(csr_ch),
      .fail_count(fail_count), .pending(pending), .vertex_count(vertex_count),
      .div_count(div_count), .sat_count(sat_count)
   );

   always #6 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.src_y = '0;
      req_ch.src_z = '0;
      req_ch.src_x = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT) begin
         $display("timeout at cycle %0d", cycle);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ch.ready <= !reset && ($urandom_range(99) >= rsp_idle);

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'(signed'($urandom_range(65535)) - 32768) <<< $urandom_range(16);
         2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($urandom_range(16)) << 16;
      endcase
   endfunction

   function automatic col_type rand_col(int col);
      col_type c;
      for (int r = 0; r < ROWS; r++) begin
         case ($urandom_range(4))
            0: c[r*16 +: 16] = 16'($urandom);
            1: c[r*16 +: 16] = 16'(signed'($urandom_range(8191)) - 4096);
            2: c[r*16 +: 16] = 16'h0;
            default: c[r*16 +: 16] = (r == col) ? 16'h1000 : 16'($urandom_range(511));
         endcase
      end
      return c;
   endfunction

   // valid stays up after the transfer so the next vertex can follow at once
   task automatic send_vertex(logic [31:0] y, logic [31:0] z, logic [31:0] x);
      while ($urandom_range(99) < req_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.src_y <= y;
      req_ch.src_z <= z;
      req_ch.src_x <= x;
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, col_type d);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= d;
      @(negedge clock);
      while (!csr_ch.ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (TOTAL_LAT + 4) @(posedge clock);
   endtask

   task automatic load_matrix(col_type c0, col_type c1, col_type c2, col_type c3);
      drain();
      write_reg(CSR_MAT_COL0, c0);
      write_reg(CSR_MAT_COL1, c1);
      write_reg(CSR_MAT_COL2, c2);
      write_reg(CSR_MAT_COL3, c3);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_idle = 32;
      rsp_idle = 79;

      // identity: w is 1.0, extremes pass through unchanged
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
      // w from src_x only: zero w passes the undivided sums
      load_matrix(MAT_COL0_RST | 64'h1000_0000_0000_0000, MAT_COL1_RST, MAT_COL2_RST,
                  64'h0000_1000_0000_0000);
      send_vertex(32'h0003_0000, 32'h0005_0000, 32'h0);
      send_vertex(32'h7FFF_FFFF, 32'h1, 32'h0);
      send_vertex(32'h0007_0000, 32'hFFF9_0000, 32'h0002_0000);
      send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      // tiny w saturates both ways; the last vertex has a large negative w
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      // all ones and extreme coefficients
      load_matrix('1, 64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_0000_0000_0000);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vertex(32'h0, 32'h0, 32'h0);
      // out of range index is ignored
      drain();
      write_reg(8'hFF, 64'h0);
      write_reg(8'h04, 64'h0);
      csr_ch.valid <= 1'b0;
      send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      load_matrix('0, '0, '0, '0);
      send_vertex(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F);

      for (int phase = 0; phase < 3; phase++) begin
         req_idle = (phase == 0) ? 32 : (phase == 1 ? 79 : 0);
         rsp_idle = (phase == 0) ? 79 : (phase == 1 ? 32 : 0);
         for (int blk = 0; blk < 5; blk++) begin
            load_matrix(rand_col(0), rand_col(1), rand_col(2), rand_col(3));
            repeat (50) send_vertex(rand_coord(), rand_coord(), rand_coord());
         end
      end
      load_matrix(MAT_COL0_RST, MAT_COL1_RST, MAT_COL2_RST, MAT_COL3_RST);
      repeat (10) send_vertex(rand_coord(), rand_coord(), rand_coord());

      drain();
      $display("checked %0d vertices over 20 matrix loads, %0d divided, %0d saturated",
               vertex_count, div_count, sat_count);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
